[hw/rtl/crc8fp_pkg.sv]
package crc8fp_pkg;

    localparam int          DEF_MAX_PAYLOAD = 32;
    localparam logic [7:0]  OWN_ADDR_RESET  = 8'h01;
    localparam logic [7:0]  SYNC_FIRST      = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND     = 8'h55;
    localparam logic [7:0]  CRC_POLY        = 8'h07;
    localparam int          CMD_RESP_BIT    = 7;

    // result field widths
    localparam int CMD_W   = 7;
    localparam int COUNT_W = 6;
    localparam int VALUE_W = 8;
    localparam int INDEX_W = 5;
    localparam int OUT_W   = 32;

    typedef enum logic [3:0] {
        ST_SYNC0,
        ST_SYNC1,
        ST_ADDR,
        ST_CMD,
        ST_LEN,
        ST_DATA,
        ST_CHECK,
        ST_READ,
        ST_SHOW
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic crc_clear;
        logic crc_update;
        logic load_addr;
        logic load_cmd;
        logic load_len;
        logic fill_clear;
        logic fill_inc;
        logic mem_write;
        logic mem_read;
        logic idx_clear;
        logic idx_inc;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_sync_first;
        logic is_sync_second;
        logic len_over;
        logic len_in_zero;
        logic fill_done;
        logic frame_pass;
        logic len_zero;
        logic idx_last;
    } t_dp_status;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/crc8_frame_parser_top.sv]
// receive deframer for frames AA 55 addr cmd len payload crc, crc-8 poly 07 init 0
// over addr, cmd, len and payload. a byte request on s_axis is taken every cycle
// while parsing. a frame that passes (crc match, addr == own address, cmd bit 7
// clear) yields a run of result requests on m_axis, one per payload byte or a single
// empty one for a zero length; each payload result is a registered payload memory
// read, then an output beat that waits while m_axis_tready is low, and byte intake
// is held off for the whole run. own address is written over the cfg channel; the
// user must write it only while idle, as the block does not enforce it; it resets
// to 1.
module crc8_frame_parser_top #(
    parameter int MAX_PAYLOAD = crc8fp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write channel: own address
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [7:0]                   i_cfg_data,
    // received bytes, tdata: rx_value[7:0]
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,
    // results, tdata: command[6:0] payload_count[12:7] payload_value[20:13]
    // value_index[25:21], zero pad above
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [crc8fp_pkg::OUT_W-1:0] m_axis_tdata,
    // tuser: has_value[0]
    output logic [0:0]                   m_axis_tuser,
    // last_of_run
    output logic                         m_axis_tlast
);
    import crc8fp_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // config is always taken
    assign o_cfg_ready = 1'b1;

    // phase sequencer and output handshake
    crc8fp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // header registers, running crc, payload store
    crc8fp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_data      (m_axis_tdata),
        .o_has_value (m_axis_tuser[0]),
        .o_last      (m_axis_tlast)
    );

endmodule

[hw/rtl/crc8fp_ctrl.sv]
module crc8fp_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  crc8fp_pkg::t_dp_status i_status,
    output crc8fp_pkg::t_dp_cmd    o_cmd
);
    import crc8fp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC0;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SYNC0: begin
                if (acc && i_status.is_sync_first) n_state = ST_SYNC1;
            end
            ST_SYNC1: begin
                if (acc) begin
                    if (i_status.is_sync_second)     n_state = ST_ADDR;
                    else if (!i_status.is_sync_first) n_state = ST_SYNC0;
                end
            end
            ST_ADDR: begin
                if (acc) n_state = ST_CMD;
            end
            ST_CMD: begin
                if (acc) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (acc) begin
                    if (i_status.len_over)         n_state = ST_SYNC0;
                    else if (i_status.len_in_zero) n_state = ST_CHECK;
                    else                           n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (acc && i_status.fill_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (acc) begin
                    if (!i_status.frame_pass)   n_state = ST_SYNC0;
                    else if (i_status.len_zero) n_state = ST_SHOW;
                    else                        n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_out_ready) begin
                    if (i_status.len_zero || i_status.idx_last) n_state = ST_SYNC0;
                    else                                       n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_SYNC0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_SYNC0: begin
                o_in_ready = 1'b1;
            end
            ST_SYNC1: begin
                o_in_ready      = 1'b1;
                o_cmd.crc_clear = acc && i_status.is_sync_second;
            end
            ST_ADDR: begin
                o_in_ready       = 1'b1;
                o_cmd.load_addr  = acc;
                o_cmd.crc_update = acc;
            end
            ST_CMD: begin
                o_in_ready       = 1'b1;
                o_cmd.load_cmd   = acc;
                o_cmd.crc_update = acc;
            end
            ST_LEN: begin
                o_in_ready       = 1'b1;
                o_cmd.fill_clear = acc;
                o_cmd.load_len   = acc && !i_status.len_over;
                o_cmd.crc_update = acc && !i_status.len_over;
            end
            ST_DATA: begin
                o_in_ready       = 1'b1;
                o_cmd.mem_write  = acc;
                o_cmd.crc_update = acc;
                o_cmd.fill_inc   = acc;
            end
            ST_CHECK: begin
                o_in_ready       = 1'b1;
                o_cmd.fill_clear = acc;
                o_cmd.idx_clear  = acc;
            end
            ST_READ: begin
                o_cmd.mem_read = 1'b1;
            end
            ST_SHOW: begin
                o_out_valid   = 1'b1;
                o_cmd.idx_inc = i_out_ready && !i_status.len_zero && !i_status.idx_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/crc8fp_dp.sv]
module crc8fp_dp #(
    parameter int MAX_PAYLOAD = crc8fp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [7:0]                    i_byte,
    input  logic                          i_cfg_we,
    input  logic [7:0]                    i_cfg_data,
    input  crc8fp_pkg::t_dp_cmd           i_cmd,
    output crc8fp_pkg::t_dp_status        o_status,
    output logic [crc8fp_pkg::OUT_W-1:0]  o_data,
    output logic                          o_has_value,
    output logic                          o_last
);
    import crc8fp_pkg::*;

    localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    r_own_addr;
    logic [7:0]    r_addr;
    logic [7:0]    r_cmd;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_fill;
    logic [7:0]    r_crc;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_rd_data;
    logic [7:0]    mem [MAX_PAYLOAD];

    logic [CMD_W-1:0]   out_cmd;
    logic [COUNT_W-1:0] out_count;
    logic [VALUE_W-1:0] out_value;
    logic [INDEX_W-1:0] out_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_clear) begin
            r_crc <= '0;
        end else if (i_cmd.crc_update) begin
            r_crc <= crc8_byte(r_crc, i_byte);
        end
        if (i_cmd.load_addr) r_addr <= i_byte;
        if (i_cmd.load_cmd)  r_cmd  <= i_byte;
        if (i_cmd.load_len)  r_len  <= LW'(i_byte);
        if (i_cmd.fill_clear) begin
            r_fill <= '0;
        end else if (i_cmd.fill_inc) begin
            r_fill <= r_fill + LW'(1);
        end
        if (i_cmd.idx_clear) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            mem[r_fill[IW-1:0]] <= i_byte;
        end
        if (i_cmd.mem_read) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_comb begin
        o_status.is_sync_first  = (i_byte == SYNC_FIRST);
        o_status.is_sync_second = (i_byte == SYNC_SECOND);
        o_status.len_over       = (i_byte > 8'(MAX_PAYLOAD));
        o_status.len_in_zero    = (i_byte == 8'd0);
        o_status.fill_done      = ((LW+1)'(r_fill) + (LW+1)'(1)) >= (LW+1)'(r_len);
        o_status.frame_pass     = (i_byte == r_crc) && (r_addr == r_own_addr)
                                  && !r_cmd[CMD_RESP_BIT];
        o_status.len_zero       = (r_len == '0);
        o_status.idx_last       = ((LW+1)'(r_idx) + (LW+1)'(1)) == (LW+1)'(r_len);
    end

    assign o_has_value = (r_len != '0);
    assign o_last      = o_status.len_zero || o_status.idx_last;
    assign out_cmd     = r_cmd[CMD_W-1:0];
    assign out_count   = COUNT_W'(r_len);
    assign out_value   = o_has_value ? r_rd_data : '0;
    assign out_index   = o_has_value ? INDEX_W'(r_idx) : '0;
    assign o_data      = {6'd0, out_index, out_value, out_count, out_cmd};

endmodule

[bench/crc8_frame_parser_checker.sv]
module crc8_frame_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    input  logic [0:0]  i_res_user,
    input  logic        i_res_last,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fp_pkg::*;

    typedef struct packed {
        logic [6:0] command;
        logic [5:0] count;
        logic [7:0] value;
        logic [4:0] index;
        logic       has_value;
        logic       last;
    } t_frame_result;

    t_state        phase;
    logic [7:0]    node_addr;
    logic [7:0]    hdr_addr;
    logic [7:0]    hdr_cmd;
    logic [5:0]    hdr_len;
    logic [5:0]    fill_pos;
    logic [7:0]    crc_acc;
    logic [7:0]    payload_buf [DEF_MAX_PAYLOAD];
    t_frame_result frame_results [$];

    // bit-serial crc-8, msb of the byte first
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ data[k];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void queue_frame_results();
        t_frame_result r;
        r.command = hdr_cmd[6:0];
        r.count   = hdr_len;
        if (hdr_len == 6'd0) begin
            r.value     = 8'h00;
            r.index     = 5'd0;
            r.has_value = 1'b0;
            r.last      = 1'b1;
            frame_results.push_back(r);
        end else begin
            for (int i = 0; i < int'(hdr_len); i++) begin
                r.value     = payload_buf[i];
                r.index     = 5'(i);
                r.has_value = 1'b1;
                r.last      = (i == int'(hdr_len) - 1);
                frame_results.push_back(r);
            end
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        case (phase)
            ST_SYNC0: begin
                if (b == SYNC_FIRST) phase = ST_SYNC1;
            end
            ST_SYNC1: begin
                if (b == SYNC_SECOND) begin
                    phase   = ST_ADDR;
                    crc_acc = 8'h00;
                end else if (b != SYNC_FIRST) begin
                    phase = ST_SYNC0;
                end
            end
            ST_ADDR: begin
                hdr_addr = b;
                crc_acc  = crc8_next(crc_acc, b);
                phase    = ST_CMD;
            end
            ST_CMD: begin
                hdr_cmd = b;
                crc_acc = crc8_next(crc_acc, b);
                phase   = ST_LEN;
            end
            ST_LEN: begin
                fill_pos = 6'd0;
                if (int'(b) > DEF_MAX_PAYLOAD) begin
                    phase = ST_SYNC0;
                end else begin
                    hdr_len = b[5:0];
                    crc_acc = crc8_next(crc_acc, b);
                    phase   = (b == 8'd0) ? ST_CHECK : ST_DATA;
                end
            end
            ST_DATA: begin
                payload_buf[fill_pos[4:0]] = b;
                crc_acc  = crc8_next(crc_acc, b);
                fill_pos = fill_pos + 6'd1;
                if (fill_pos >= hdr_len) phase = ST_CHECK;
            end
            ST_CHECK: begin
                if (b == crc_acc && hdr_addr == node_addr && !hdr_cmd[CMD_RESP_BIT])
                    queue_frame_results();
                phase    = ST_SYNC0;
                fill_pos = 6'd0;
            end
            default: begin
                phase    = ST_SYNC0;
                fill_pos = 6'd0;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("result field %s: expected %0d, actual %0d", name, want, got);
            o_mismatches++;
        end
    endfunction

    function automatic void check_result();
        t_frame_result want;
        if (frame_results.size() == 0) begin
            $error("unexpected result: command %0d index %0d value %0d",
                   i_res_data[6:0], i_res_data[25:21], i_res_data[20:13]);
            o_mismatches++;
            return;
        end
        want = frame_results.pop_front();
        compare_field("command",       int'(want.command),   int'(i_res_data[6:0]));
        compare_field("payload_count", int'(want.count),     int'(i_res_data[12:7]));
        compare_field("payload_value", int'(want.value),     int'(i_res_data[20:13]));
        compare_field("value_index",   int'(want.index),     int'(i_res_data[25:21]));
        compare_field("tdata_pad",     0,                    int'(i_res_data[31:26]));
        compare_field("has_value",     int'(want.has_value), int'(i_res_user[0]));
        compare_field("last_of_run",   int'(want.last),      int'(i_res_last));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase        = ST_SYNC0;
            node_addr    = OWN_ADDR_RESET;
            hdr_addr     = 8'h00;
            hdr_cmd      = 8'h00;
            hdr_len      = 6'd0;
            fill_pos     = 6'd0;
            crc_acc      = 8'h00;
            o_mismatches = 0;
            frame_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) node_addr = i_cfg_data;
            if (i_rx_valid && i_rx_ready) absorb_byte(i_rx_data);
            if (i_res_valid && i_res_ready) check_result();
        end
        o_pending = frame_results.size();
    end

endmodule

[bench/tb_crc8_frame_parser_top.sv]
module tb_crc8_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fp_pkg::*;

    // long receiver hold-off, enough for a full frame's run to back up into the input
    localparam int HOLD_CYCLES  = 400;
    // a full run of 32 results, plus margin
    localparam int DRAIN_CYCLES = 80;
    // the bytes with idle gaps, the results under stalls, one hold-off and the drains
    // stay far below this limit
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int pending;

    // idling knobs, percent per cycle
    int idle_pct    = 0;
    int stall_pct   = 0;
    // a bump of hold_asked starts one long receiver hold-off
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int bytes_sent  = 0;
    // own address as last written, used to build frames that pass
    logic [7:0] own_addr_now = OWN_ADDR_RESET;

    crc8_frame_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    crc8_frame_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_rx_valid   (s_axis_tvalid),
        .i_rx_ready   (s_axis_tready),
        .i_rx_data    (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_crc8_frame_parser_top: FAIL");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // frame crc for stimulus: crc-8 poly 07, init 0
    function automatic logic [7:0] frame_crc_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        return r;
    endfunction

    // one byte request, with idle cycles ahead of it, each taken with idle_pct chance
    task automatic send_byte(input logic [7:0] b);
        int n_idle;
        n_idle = 0;
        while ($urandom_range(99) < idle_pct) n_idle++;
        if (n_idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n_idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // preamble, header, payload and crc; an oversized length stops after the length byte
    // fill < 0 gives random payload bytes, otherwise every byte is fill
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [7:0] len, input bit bad_crc,
                              input bit extra_sync, input int fill);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        if (extra_sync) send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(addr);
        crc = frame_crc_step(crc, addr);
        send_byte(cmd);
        crc = frame_crc_step(crc, cmd);
        send_byte(len);
        if (int'(len) > DEF_MAX_PAYLOAD) return;
        crc = frame_crc_step(crc, len);
        for (int i = 0; i < int'(len); i++) begin
            b   = (fill < 0) ? 8'($urandom) : 8'(fill);
            crc = frame_crc_step(crc, b);
            send_byte(b);
        end
        send_byte(bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc);
    endtask

    // mostly frames that pass, the rest foreign, response, bad crc, oversized or noise
    task automatic random_frame();
        int         kind;
        int         pick;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] b;
        kind = $urandom_range(99);
        pick = $urandom_range(9);
        addr = own_addr_now;
        cmd  = 8'($urandom_range(0, 127));
        // mostly short payloads, some of any length, a few of the maximum
        if (pick < 6)      len = 8'($urandom_range(0, 4));
        else if (pick < 9) len = 8'($urandom_range(0, DEF_MAX_PAYLOAD));
        else               len = 8'(DEF_MAX_PAYLOAD);
        if (kind < 55) begin
            send_frame(addr, cmd, len, 1'b0, $urandom_range(3) == 0, -1);
        end else if (kind < 65) begin
            // foreign address
            addr = own_addr_now ^ 8'($urandom_range(1, 255));
            send_frame(addr, cmd, len, 1'b0, 1'b0, -1);
        end else if (kind < 73) begin
            send_frame(addr, cmd | 8'h80, len, 1'b0, 1'b0, -1);
        end else if (kind < 81) begin
            send_frame(addr, cmd, len, 1'b1, 1'b0, -1);
        end else if (kind < 87) begin
            len = 8'($urandom_range(DEF_MAX_PAYLOAD + 1, 255));
            send_frame(addr, cmd, len, 1'b0, 1'b0, -1);
        end else begin
            // loose bytes, preamble-heavy; no loose 55, so the parser stays in the hunt
            repeat ($urandom_range(1, 4)) begin
                b = ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom);
                if (b == SYNC_SECOND) b = 8'h00;
                send_byte(b);
            end
        end
    endtask

    task automatic run_random(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) random_frame();
    endtask

    // a zero drops a dangling first preamble byte back to the hunt
    task automatic flush_to_hunt();
        send_byte(8'h00);
    endtask

    // stop offering bytes until every expected result has come
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // idle the block fully: results drained, then a run's worth of cycles
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_address(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        own_addr_now = value;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 0: reset address, no idling, directed cases first
        // repeated preamble, then an empty payload with command 0
        send_frame(OWN_ADDR_RESET, 8'h00, 8'd0, 1'b0, 1'b1, -1);
        // noise right after the first preamble byte
        send_byte(SYNC_FIRST);
        send_byte(8'h5A);
        // length one above the maximum
        send_frame(OWN_ADDR_RESET, 8'h7F, 8'(DEF_MAX_PAYLOAD + 1), 1'b0, 1'b0, -1);
        // response frame (command bit 7 set), all-ones payload
        send_frame(OWN_ADDR_RESET, 8'hFF, 8'd1, 1'b0, 1'b0, 8'hFF);
        // highest command that passes, zero payload byte
        send_frame(OWN_ADDR_RESET, 8'h7F, 8'd1, 1'b0, 1'b0, 8'h00);
        run_random(25);
        flush_to_hunt();
        settle();
        write_own_address(8'h00);

        // phase 1: sender idles about half the time
        idle_pct = 52;
        run_random(25);
        flush_to_hunt();
        settle();
        write_own_address(8'hFF);

        // phase 2: receiver stalls, and one long hold-off while bytes keep coming
        idle_pct  = 0;
        stall_pct = 52;
        hold_asked++;
        send_frame(own_addr_now, 8'($urandom_range(0, 127)), 8'(DEF_MAX_PAYLOAD),
                   1'b0, 1'b0, -1);
        run_random(25);
        flush_to_hunt();
        settle();
        write_own_address(8'($urandom_range(0, 255)));

        // phase 3: both sides idle now and then, with a full pause midway
        idle_pct  = 18;
        stall_pct = 18;
        run_random(12);
        wait_results();
        run_random(13);
        flush_to_hunt();
        settle();

        if (mismatches == 0) begin
            $display("tb_crc8_frame_parser_top: PASS");
        end else begin
            $display("tb_crc8_frame_parser_top: FAIL");
        end
        $finish;
    end

endmodule
